// ===== hw/rtl/ccp_pkg.sv =====
package ccp_pkg;

  localparam int unsigned CoordBits = 24;
  localparam int unsigned FracBits  = 8;

  typedef struct packed {
    logic signed [CoordBits-1:0] self_center_x;
    logic signed [CoordBits-1:0] self_center_y;
    logic        [CoordBits-2:0] self_radius;
    logic signed [CoordBits-1:0] other_center_x;
    logic signed [CoordBits-1:0] other_center_y;
    logic        [CoordBits-2:0] other_radius;
  } ccp_in_t;

  typedef struct packed {
    logic                        hit;
    logic signed [CoordBits-1:0] contact_x;
    logic signed [CoordBits-1:0] contact_y;
  } ccp_out_t;

endpackage

// ===== hw/rtl/circle_contact_point.sv =====
// Circle contact point. Takes one item per cycle while in_ready_o is high and
// returns one result per item. The front computes the squared distance and
// overlap test in two stages; a four-entry queue decouples it from the back,
// which runs a bit-per-stage square root (W+1 stages, W being the coordinate
// width of the package), one multiply stage, a bit-per-stage divider (2*W
// stages) and a saturating add. Each pipeline advances only when its output
// can be taken or its last stage is empty, so stalls on the output side back
// up through the queues and hold each pipeline in place.
module circle_contact_point #(
  parameter int unsigned FRAC_BITS  = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ccp_pkg::ccp_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ccp_pkg::ccp_out_t out_data_o
);
  localparam int unsigned W  = ccp_pkg::CoordBits;
  localparam int unsigned MW = 1 + 2*(W+1) + (2*W+2) + 2*W + (W-1);
  localparam int unsigned BW = 1 + 2*W;

  typedef struct packed {
    logic                hit;
    logic signed [W:0]   dx;
    logic signed [W:0]   dy;
    logic [2*W+1:0]      d2;
    logic signed [W-1:0] sx;
    logic signed [W-1:0] sy;
    logic [W-2:0]        sr;
  } mid_t;

  // front
  logic f_en, f_valid;
  mid_t f_mid;
  logic q_ready;

  assign f_en = !f_valid || q_ready;
  assign in_ready_o = f_en;

  ccp_front #(.CoordBits(W)) u_front (
    .clk_i, .rst_ni,
    .en_i   (f_en),
    .valid_i(in_valid_i),
    .sx_i   (W'(in_data_i.self_center_x)),
    .sy_i   (W'(in_data_i.self_center_y)),
    .sr_i   ((W-1)'(in_data_i.self_radius)),
    .ox_i   (W'(in_data_i.other_center_x)),
    .oy_i   (W'(in_data_i.other_center_y)),
    .or_i   ((W-1)'(in_data_i.other_radius)),
    .valid_o(f_valid),
    .hit_o  (f_mid.hit),
    .dx_o   (f_mid.dx),
    .dy_o   (f_mid.dy),
    .d2_o   (f_mid.d2),
    .sx_o   (f_mid.sx),
    .sy_o   (f_mid.sy),
    .sr_o   (f_mid.sr)
  );

  // queue between front and back
  logic q_valid, b_en, b_valid;
  mid_t q_mid;
  logic [MW-1:0] q_data;

  ccp_fifo #(.Width(MW), .Depth(4)) u_queue (
    .clk_i, .rst_ni,
    .in_valid_i (f_valid),
    .in_ready_o (q_ready),
    .in_data_i  (f_mid),
    .out_valid_o(q_valid),
    .out_ready_i(b_en),
    .out_data_o (q_data)
  );
  assign q_mid = q_data;

  // back advances when its last stage is empty or being taken
  logic s_ready;
  assign b_en = !b_valid || s_ready;

  logic          b_hit;
  logic [W-1:0]  b_cx, b_cy;

  ccp_back #(.CoordBits(W), .FracBits(FRAC_BITS)) u_back (
    .clk_i, .rst_ni,
    .en_i   (b_en),
    .valid_i(q_valid),
    .hit_i  (q_mid.hit),
    .dx_i   (q_mid.dx),
    .dy_i   (q_mid.dy),
    .d2_i   (q_mid.d2),
    .sx_i   (q_mid.sx),
    .sy_i   (q_mid.sy),
    .sr_i   (q_mid.sr),
    .valid_o(b_valid),
    .hit_o  (b_hit),
    .cx_o   (b_cx),
    .cy_o   (b_cy)
  );

  // output skid queue
  logic [BW-1:0] o_data;
  ccp_fifo #(.Width(BW), .Depth(2)) u_out (
    .clk_i, .rst_ni,
    .in_valid_i (b_valid),
    .in_ready_o (s_ready),
    .in_data_i  ({b_hit, b_cx, b_cy}),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (o_data)
  );

  assign out_data_o.hit       = o_data[BW-1];
  assign out_data_o.contact_x = ccp_pkg::CoordBits'(o_data[2*W-1:W]);
  assign out_data_o.contact_y = ccp_pkg::CoordBits'(o_data[W-1:0]);

  // a miss always shows the same value on both coordinates
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.hit) |->
      (out_data_o.contact_x == out_data_o.contact_y))
    else $error("miss result coordinates differ");

  // the front never holds a valid item against a full queue without stalling
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (f_valid && !q_ready) |-> !in_ready_o)
    else $error("front advanced into a full queue");

  // a zero squared distance is never a hit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (f_valid && f_mid.d2 == '0) |-> !f_mid.hit)
    else $error("coincident centers flagged as hit");
endmodule

// ===== hw/rtl/ccp_fifo.sv =====
// Small ready/valid queue; full throughput, registered output side.
module ccp_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [Width-1:0] in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [Width-1:0] out_data_o
);
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

  logic [Width-1:0] mem_q [Depth];
  logic [Aw-1:0]    wr_q, rd_q;
  logic [Aw:0]      cnt_q;
  logic             push, pop;

  assign in_ready_o  = (cnt_q != Depth[Aw:0]);
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_q];
  assign push = in_valid_i & in_ready_o;
  assign pop  = out_valid_o & out_ready_i;

  // storage
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_data_i;
  end

  // pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= (wr_q == Aw'(Depth - 1)) ? '0 : wr_q + 1'b1;
      if (pop)  rd_q <= (rd_q == Aw'(Depth - 1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + (Aw+1)'(push) - (Aw+1)'(pop);
    end
  end
endmodule

// ===== hw/rtl/ccp_front.sv =====
// Front: differences, squared distance, overlap test. Two stages.
module ccp_front #(
  parameter int unsigned CoordBits = 24
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic signed [CoordBits-1:0] sx_i,
  input  logic signed [CoordBits-1:0] sy_i,
  input  logic        [CoordBits-2:0] sr_i,
  input  logic signed [CoordBits-1:0] ox_i,
  input  logic signed [CoordBits-1:0] oy_i,
  input  logic        [CoordBits-2:0] or_i,
  output logic                        valid_o,
  output logic                        hit_o,
  output logic signed [CoordBits:0]   dx_o,
  output logic signed [CoordBits:0]   dy_o,
  output logic [2*CoordBits+1:0]      d2_o,
  output logic signed [CoordBits-1:0] sx_o,
  output logic signed [CoordBits-1:0] sy_o,
  output logic        [CoordBits-2:0] sr_o
);
  localparam int unsigned W = CoordBits;

  logic              v1_q, v2_q;
  logic signed [W:0] dx1_q, dy1_q, dx2_q, dy2_q;
  logic [W-1:0]      rs1_q;
  logic [W-1:0]      sx1_q, sy1_q, sx2_q, sy2_q;
  logic [W-2:0]      sr1_q, sr2_q;
  logic [W:0]        ax, ay;
  logic [2*W+1:0]    d2_d, d2_q;
  logic              hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  assign ax = dx1_q[W] ? (W+1)'(-dx1_q) : dx1_q;
  assign ay = dy1_q[W] ? (W+1)'(-dy1_q) : dy1_q;
  assign d2_d = (2*W+2)'(ax * ax) + (2*W+2)'(ay * ay);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // stage 1: differences and radius sum
      dx1_q <= (W+1)'(ox_i) - (W+1)'(sx_i);
      dy1_q <= (W+1)'(oy_i) - (W+1)'(sy_i);
      rs1_q <= W'(sr_i) + W'(or_i);
      sx1_q <= sx_i;
      sy1_q <= sy_i;
      sr1_q <= sr_i;
      // stage 2: squares and compare
      d2_q  <= d2_d;
      hit_q <= (d2_d != '0) && (d2_d <= (2*W+2)'(rs1_q * rs1_q));
      dx2_q <= dx1_q;
      dy2_q <= dy1_q;
      sx2_q <= sx1_q;
      sy2_q <= sy1_q;
      sr2_q <= sr1_q;
    end
  end

  assign valid_o = v2_q;
  assign hit_o   = hit_q;
  assign dx_o    = dx2_q;
  assign dy_o    = dy2_q;
  assign d2_o    = d2_q;
  assign sx_o    = sx2_q;
  assign sy_o    = sy2_q;
  assign sr_o    = sr2_q;
endmodule

// ===== hw/rtl/ccp_back.sv =====
// Back: pipelined square root (one bit per stage), products, two pipelined
// restoring dividers (one bit per stage), saturating add.
module ccp_back #(
  parameter int unsigned CoordBits = 24,
  parameter int unsigned FracBits  = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic                        hit_i,
  input  logic signed [CoordBits:0]   dx_i,
  input  logic signed [CoordBits:0]   dy_i,
  input  logic [2*CoordBits+1:0]      d2_i,
  input  logic signed [CoordBits-1:0] sx_i,
  input  logic signed [CoordBits-1:0] sy_i,
  input  logic        [CoordBits-2:0] sr_i,
  output logic                        valid_o,
  output logic                        hit_o,
  output logic signed [CoordBits-1:0] cx_o,
  output logic signed [CoordBits-1:0] cy_o
);
  localparam int unsigned W  = CoordBits;
  localparam int unsigned DW = 2*W+2;   // squared distance width
  localparam int unsigned RW = W+1;     // root width
  localparam int unsigned PW = 2*W;     // product r*|d| width
  localparam int unsigned SN = RW;      // sqrt stages
  localparam int unsigned QN = PW;      // divide stages (quotient bits)

  typedef struct packed {
    logic                hit;
    logic                nx;
    logic                ny;
    logic signed [W-1:0] sx;
    logic signed [W-1:0] sy;
  } side_t;

  // ---- square root pipeline ----
  logic [SN:0]       sv_q;
  side_t             ss_q [SN+1];
  logic [DW-1:0]     srem_q [SN+1];
  logic [RW-1:0]     sroot_q [SN+1];
  logic [W:0]        sax_q [SN+1];
  logic [W:0]        say_q [SN+1];
  logic [W-2:0]      ssr_q [SN+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sv_q <= '0;
    else if (en_i) sv_q <= {sv_q[SN-1:0], valid_i};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ss_q[0]    <= '{hit: hit_i, nx: dx_i[W], ny: dy_i[W], sx: sx_i, sy: sy_i};
      srem_q[0]  <= d2_i;
      sroot_q[0] <= '0;
      sax_q[0]   <= dx_i[W] ? (W+1)'(-dx_i) : dx_i;
      say_q[0]   <= dy_i[W] ? (W+1)'(-dy_i) : dy_i;
      ssr_q[0]   <= sr_i;
    end
  end

  for (genvar k = 0; k < SN; k++) begin : g_sqrt
    localparam int unsigned B = SN - 1 - k;
    logic [DW-1:0] trial;
    logic [RW-1:0] cand;
    // (root + 2^B)^2 - root^2 = 2^B*(2*root + 2^B); remainder tracks v - root^2
    assign cand  = sroot_q[k] | (RW'(1) << B);
    assign trial = (DW'(sroot_q[k]) << (B + 1)) + (DW'(1) << (2*B));
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (srem_q[k] >= trial) begin
          srem_q[k+1]  <= srem_q[k] - trial;
          sroot_q[k+1] <= cand;
        end else begin
          srem_q[k+1]  <= srem_q[k];
          sroot_q[k+1] <= sroot_q[k];
        end
        ss_q[k+1]  <= ss_q[k];
        sax_q[k+1] <= sax_q[k];
        say_q[k+1] <= say_q[k];
        ssr_q[k+1] <= ssr_q[k];
      end
    end
  end

  // ---- product stage ----
  logic          pv_q;
  side_t         ps_q;
  logic [PW-1:0] px_q, py_q;
  logic [RW-1:0] pd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pv_q <= 1'b0;
    else if (en_i) pv_q <= sv_q[SN];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ps_q <= ss_q[SN];
      px_q <= PW'(ssr_q[SN] * sax_q[SN]);
      py_q <= PW'(ssr_q[SN] * say_q[SN]);
      pd_q <= (sroot_q[SN] == '0) ? RW'(1) : sroot_q[SN];
    end
  end

  // ---- divider pipeline (restoring, one quotient bit per stage) ----
  logic [QN:0]   dv_q;
  side_t         ds_q [QN+1];
  logic [PW-1:0] nx_q [QN+1], ny_q [QN+1];
  logic [RW:0]   rx_q [QN+1], ry_q [QN+1];
  logic [RW-1:0] dd_q [QN+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dv_q <= '0;
    else if (en_i) dv_q <= {dv_q[QN-1:0], pv_q};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ds_q[0] <= ps_q;
      nx_q[0] <= px_q;
      ny_q[0] <= py_q;
      rx_q[0] <= '0;
      ry_q[0] <= '0;
      dd_q[0] <= pd_q;
    end
  end

  for (genvar k = 0; k < QN; k++) begin : g_div
    logic [RW:0] tx, ty;
    assign tx = {rx_q[k][RW-1:0], nx_q[k][PW-1]};
    assign ty = {ry_q[k][RW-1:0], ny_q[k][PW-1]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (tx >= {1'b0, dd_q[k]}) begin
          rx_q[k+1] <= tx - {1'b0, dd_q[k]};
          nx_q[k+1] <= {nx_q[k][PW-2:0], 1'b1};
        end else begin
          rx_q[k+1] <= tx;
          nx_q[k+1] <= {nx_q[k][PW-2:0], 1'b0};
        end
        if (ty >= {1'b0, dd_q[k]}) begin
          ry_q[k+1] <= ty - {1'b0, dd_q[k]};
          ny_q[k+1] <= {ny_q[k][PW-2:0], 1'b1};
        end else begin
          ry_q[k+1] <= ty;
          ny_q[k+1] <= {ny_q[k][PW-2:0], 1'b0};
        end
        ds_q[k+1] <= ds_q[k];
        dd_q[k+1] <= dd_q[k];
      end
    end
  end

  // ---- offset, saturate, miss value ----
  localparam logic signed [PW+1:0] Top = (PW+2)'((64'(1) << (W-1)) - 1);
  localparam logic signed [PW+1:0] Bot = -Top - 1;
  localparam logic signed [PW+1:0] MissW = -((PW+2)'(1) << FracBits);
  localparam logic signed [W-1:0]  Miss =
    (MissW < Bot) ? W'(Bot) : W'(MissW);

  function automatic logic signed [W-1:0] rim(logic signed [W-1:0] c,
                                              logic neg, logic [PW-1:0] q);
    logic signed [PW+1:0] off, sum;
    off = neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
    sum = (PW+2)'(c) + off;
    if (sum > Top)      rim = W'(Top);
    else if (sum < Bot) rim = W'(Bot);
    else                rim = W'(sum);
  endfunction

  logic                ov_q, oh_q;
  logic signed [W-1:0] ox_q, oy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (en_i) ov_q <= dv_q[QN];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      oh_q <= ds_q[QN].hit;
      ox_q <= ds_q[QN].hit ? rim(ds_q[QN].sx, ds_q[QN].nx, nx_q[QN]) : Miss;
      oy_q <= ds_q[QN].hit ? rim(ds_q[QN].sy, ds_q[QN].ny, ny_q[QN]) : Miss;
    end
  end

  assign valid_o = ov_q;
  assign hit_o   = oh_q;
  assign cx_o    = ox_q;
  assign cy_o    = oy_q;
endmodule

// ===== verif/circle_contact_point_test.sv =====
`timescale 1ns / 1ps

module circle_contact_point_test;

  localparam longint CoordMax = (longint'(1) <<< (ccp_pkg::CoordBits - 1)) - 1;
  localparam longint CoordMin = -CoordMax - 1;
  localparam int unsigned LatencyCycles = 3 * ccp_pkg::CoordBits + 8;
  localparam int unsigned HoldOffCycles = 400;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  ccp_pkg::ccp_in_t  in_data_i;
  logic              out_valid_o;
  logic              out_ready_i;
  ccp_pkg::ccp_out_t out_data_o;

  ccp_pkg::ccp_out_t contact_queue[$];
  int unsigned n_errors;
  int unsigned n_sent;
  int unsigned n_hits;
  int unsigned n_checked;
  bit          send_gaps;
  bit          recv_stalls;
  bit          hold_req;

  circle_contact_point u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Saturate to the signed coordinate range
  function automatic longint clamp_coord(longint v);
    if (v > CoordMax) return CoordMax;
    if (v < CoordMin) return CoordMin;
    return v;
  endfunction

  // Floor square root of the squared center distance
  function automatic longint floor_sqrt(longint v);
    longint res;
    longint c;
    res = 0;
    for (int b = ccp_pkg::CoordBits + 1; b >= 0; b--) begin
      c = res | (longint'(1) <<< b);
      if (c * c <= v) res = c;
    end
    return res;
  endfunction

  // Point on this rim along one axis, truncated toward zero
  function automatic longint rim_coord(longint c, longint r, longint d, longint root);
    longint q;
    q = (r * (d < 0 ? -d : d)) / root;
    return clamp_coord(c + (d < 0 ? -q : q));
  endfunction

  function automatic ccp_pkg::ccp_out_t predict_contact(ccp_pkg::ccp_in_t it);
    ccp_pkg::ccp_out_t res;
    longint   sx, sy, sr, ox, oy, orad, dx, dy, d2, rs, root, miss;
    sx   = longint'($signed(it.self_center_x));
    sy   = longint'($signed(it.self_center_y));
    sr   = longint'({1'b0, it.self_radius});
    ox   = longint'($signed(it.other_center_x));
    oy   = longint'($signed(it.other_center_y));
    orad = longint'({1'b0, it.other_radius});
    dx   = ox - sx;
    dy   = oy - sy;
    d2   = dx * dx + dy * dy;
    rs   = sr + orad;
    miss = clamp_coord(-(longint'(1) <<< ccp_pkg::FracBits));
    if (d2 != 0 && d2 <= rs * rs) begin
      root          = floor_sqrt(d2);
      res.hit       = 1'b1;
      res.contact_x = ccp_pkg::CoordBits'(rim_coord(sx, sr, dx, root));
      res.contact_y = ccp_pkg::CoordBits'(rim_coord(sy, sr, dy, root));
    end else begin
      res.hit       = 1'b0;
      res.contact_x = ccp_pkg::CoordBits'(miss);
      res.contact_y = ccp_pkg::CoordBits'(miss);
    end
    return res;
  endfunction

  // Send one item; valid stays high afterwards until the next gap or drop
  task automatic send_item(ccp_pkg::ccp_in_t it);
    int unsigned gap;
    gap = send_gaps ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    contact_queue.push_back(predict_contact(it));
    n_sent++;
  endtask

  // Lower valid and wait until every result is back
  task automatic drain_all();
    in_valid_i <= 1'b0;
    while (contact_queue.size() != 0) @(posedge clk_i);
  endtask

  function automatic ccp_pkg::ccp_in_t make_item(longint sx, longint sy, longint sr,
                                                 longint ox, longint oy, longint orad);
    ccp_pkg::ccp_in_t it;
    it.self_center_x  = ccp_pkg::CoordBits'(sx);
    it.self_center_y  = ccp_pkg::CoordBits'(sy);
    it.self_radius    = (ccp_pkg::CoordBits - 1)'(sr);
    it.other_center_x = ccp_pkg::CoordBits'(ox);
    it.other_center_y = ccp_pkg::CoordBits'(oy);
    it.other_radius   = (ccp_pkg::CoordBits - 1)'(orad);
    return it;
  endfunction

  // Mostly nearby pairs so that overlaps are common, some fully random
  function automatic ccp_pkg::ccp_in_t random_item();
    ccp_pkg::ccp_in_t it;
    int unsigned      span;
    longint           dx, dy;
    it = make_item($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    if ($urandom_range(0, 3) != 0) begin
      span = $urandom_range(1, ccp_pkg::CoordBits);
      dx   = longint'($urandom_range(0, (1 << span) - 1)) - (longint'(1) <<< (span - 1));
      dy   = longint'($urandom_range(0, (1 << span) - 1)) - (longint'(1) <<< (span - 1));
      it.other_center_x = ccp_pkg::CoordBits'(longint'($signed(it.self_center_x)) + dx);
      it.other_center_y = ccp_pkg::CoordBits'(longint'($signed(it.self_center_y)) + dy);
      it.self_radius    = (ccp_pkg::CoordBits - 1)'($urandom_range(0, (1 << span) - 1));
      it.other_radius   = (ccp_pkg::CoordBits - 1)'($urandom_range(0, (1 << span) - 1));
    end
    return it;
  endfunction

  // Receiver: per-transfer stall, plus a long hold-off on request
  initial begin
    int unsigned w;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end
      w = recv_stalls ? $urandom_range(0, 19) : 0;
      if (w > 0) begin
        out_ready_i <= 1'b0;
        repeat (w) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Result check against the oldest prediction
  always @(posedge clk_i) begin
    ccp_pkg::ccp_out_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (contact_queue.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data_o);
        n_errors++;
      end else begin
        exp_res = contact_queue.pop_front();
        n_checked++;
        if (exp_res.hit) n_hits++;
        if (out_data_o.hit !== exp_res.hit) begin
          $display("%0t: hit expected %0d actual %0d", $time, exp_res.hit, out_data_o.hit);
          n_errors++;
        end
        if (out_data_o.contact_x !== exp_res.contact_x) begin
          $display("%0t: contact_x expected %0d actual %0d", $time,
                   exp_res.contact_x, out_data_o.contact_x);
          n_errors++;
        end
        if (out_data_o.contact_y !== exp_res.contact_y) begin
          $display("%0t: contact_y expected %0d actual %0d", $time,
                   exp_res.contact_y, out_data_o.contact_y);
          n_errors++;
        end
      end
    end
  end

  // Extremes, coincident centers, exact touch, miss and saturation
  task automatic test_directed();
    send_gaps   = 1'b1;
    recv_stalls = 1'b1;
    send_item(make_item(0, 0, 0, 0, 0, 0));
    send_item(make_item(1000, -2000, 500, 1000, -2000, 700));
    send_item(make_item(0, 0, 200, 300, 400, 300));
    send_item(make_item(0, 0, 200, 300, 400, 299));
    send_item(make_item(0, 0, 100, 256, 0, 200));
    send_item(make_item(0, 0, 100, -256, 0, 200));
    send_item(make_item(0, 0, 100, 0, -256, 200));
    send_item(make_item(-5, 7, 3, -6, 7, 0));
    send_item(make_item(CoordMax, CoordMax, CoordMax, CoordMin, CoordMin, CoordMax));
    send_item(make_item(CoordMin, CoordMin, CoordMax, CoordMax, CoordMax, CoordMax));
    send_item(make_item(CoordMax, 0, CoordMax, CoordMax - 1, 0, 0));
    send_item(make_item(CoordMin, 0, CoordMax, CoordMin + 1, 0, 0));
    send_item(make_item(CoordMax, CoordMin, CoordMax, CoordMax, CoordMin, CoordMax));
    send_item(make_item(-1, -1, CoordMax, -1, -1, CoordMax));
    send_item(make_item(CoordMin, CoordMax, 0, CoordMax, CoordMin, 0));
    send_item(make_item(1, 1, 1, 0, 0, 1));
    send_item(make_item(0, 0, CoordMax, 3, 4, 0));
    drain_all();
  endtask

  task automatic test_random_idle(int unsigned n);
    send_gaps   = 1'b1;
    recv_stalls = 1'b1;
    repeat (n) send_item(random_item());
    drain_all();
  endtask

  task automatic test_full_rate(int unsigned n);
    send_gaps   = 1'b0;
    recv_stalls = 1'b0;
    repeat (n) send_item(random_item());
    drain_all();
  endtask

  // Long output hold-off while input keeps coming, so the pipe fills
  task automatic test_backpressure(int unsigned n);
    send_gaps   = 1'b0;
    recv_stalls = 1'b1;
    hold_req    = 1'b1;
    repeat (n) send_item(random_item());
    drain_all();
  endtask

  // Stop the run after a generous fixed time
  initial begin
    #8ms;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    n_errors    = 0;
    n_sent      = 0;
    n_hits      = 0;
    n_checked   = 0;
    hold_req    = 1'b0;
    send_gaps   = 1'b0;
    recv_stalls = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_idle(600);
    test_full_rate(400);
    test_backpressure(400);
    test_random_idle(450);

    repeat (LatencyCycles + 50) @(posedge clk_i);
    $display("Sent %0d circle pairs, checked %0d contact results (%0d hits)",
             n_sent, n_checked, n_hits);
    $display("Covered gaps, full rate, a long output hold-off and drained pauses");
    if (n_errors == 0 && contact_queue.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/ccp_pkg.sv
hw/rtl/ccp_fifo.sv
hw/rtl/ccp_front.sv
hw/rtl/ccp_back.sv
hw/rtl/circle_contact_point.sv
verif/circle_contact_point_test.sv
